// ===== rtl/rss_pkg.sv =====
`default_nettype none
package rss_pkg;
  localparam int SampleBits = 32;
  localparam int CountBits = 32;
  localparam int FracBits = 8;
  localparam int OutBits = 40;
  localparam int AccBits = 64;
  localparam int ScaleBits = 16;
  // Divider: 128-bit dividend, 64-bit divisor, one quotient bit per cycle.
  localparam int DivNumBits = 128;
  localparam int DivDenBits = 64;
  localparam int DivCntBits = $clog2(DivNumBits + 1);
  // Root: 64 result bits over a 128-bit radicand, two radicand bits per step.
  localparam int RootBits = 64;
  localparam int RootCntBits = $clog2(RootBits + 1);
  localparam int MulCntBits = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_MUL,
    ST_MIN,
    ST_MAX,
    ST_MEAN,
    ST_ROOT,
    ST_DEV,
    ST_OUT
  } rss_state_t;

  typedef enum logic [1:0] {
    SEL_MIN,
    SEL_MAX,
    SEL_MEAN,
    SEL_DEV
  } rss_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     accum;
    logic     mul_start;
    logic     div_start;
    rss_sel_t div_sel;
    logic     root_start;
    logic     out_load;
  } rss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic root_done;
  } rss_sts_t;
endpackage
`default_nettype wire

// ===== rtl/rss_datapath.sv =====
`default_nettype none
module rss_datapath
  import rss_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rss_cmd_t             cmd,
  output rss_sts_t                  sts,
  input  wire logic [SampleBits-1:0] sample_in,
  input  wire logic [ScaleBits-1:0] scale_in,
  output logic [CountBits-1:0]      sample_count,
  output logic [OutBits-1:0]        minimum_scaled,
  output logic [OutBits-1:0]        maximum_scaled,
  output logic [OutBits-1:0]        mean_scaled,
  output logic [OutBits-1:0]        deviation_scaled,
  output logic                      overflow
);
  localparam logic [OutBits-1:0] OutMax = '1;

  // Accumulator state.
  logic [CountBits-1:0]  count_r;
  logic [AccBits-1:0]    sum_r;
  logic [AccBits-1:0]    sq_r;
  logic [SampleBits-1:0] min_r;
  logic [SampleBits-1:0] max_r;
  logic [SampleBits-1:0] samp_r;
  logic [ScaleBits-1:0]  scale_r;
  logic                  wrap_r;

  logic [2*SampleBits-1:0] square;
  logic [AccBits:0]        sum_ext;
  logic [AccBits:0]        sq_ext;
  logic                    wrap;

  assign square  = samp_r * samp_r;
  assign sum_ext = {1'b0, sum_r} + {{(AccBits+1-SampleBits){1'b0}}, samp_r};
  assign sq_ext  = {1'b0, sq_r} + {{(AccBits+1-2*SampleBits){1'b0}}, square};
  assign wrap    = (count_r == {CountBits{1'b1}}) || sum_ext[AccBits] || sq_ext[AccBits];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      min_r   <= '0;
      max_r   <= '0;
    end else if (cmd.accum) begin
      if (wrap) begin
        count_r <= '0;
        sum_r   <= '0;
        sq_r    <= '0;
      end else begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_ext[AccBits-1:0];
        sq_r    <= sq_ext[AccBits-1:0];
        if (samp_r > max_r) max_r <= samp_r;
        if (min_r == '0 || samp_r < min_r) min_r <= samp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r  <= sample_in;
      scale_r <= (scale_in == '0) ? {{(ScaleBits-1){1'b0}}, 1'b1} : scale_in;
    end
    if (cmd.accum) wrap_r <= wrap;
  end

  // Sequential 64x64 multiplier: four 32x32 partial products, n*sumsq then sum^2.
  logic [2*AccBits-1:0] prod_a_r;
  logic [2*AccBits-1:0] prod_b_r;
  logic [MulCntBits-1:0] mcnt_r;
  logic                 mbusy_r;
  logic [AccBits-1:0]   mop_x;
  logic [AccBits-1:0]   mop_y;
  logic [31:0]          mx;
  logic [31:0]          my;
  logic [63:0]          pp_r;
  logic [1:0]           pp_idx_r;
  logic                 pp_sec_r;
  logic                 pp_vld_r;
  logic [2*AccBits-1:0] pp_sh;

  assign mop_x = mcnt_r[2] ? sum_r : {{(AccBits-CountBits){1'b0}}, count_r};
  assign mop_y = mcnt_r[2] ? sum_r : sq_r;
  assign mx    = mcnt_r[0] ? mop_x[63:32] : mop_x[31:0];
  assign my    = mcnt_r[1] ? mop_y[63:32] : mop_y[31:0];
  assign pp_sh = {64'd0, pp_r} << (32 * ({1'b0, pp_idx_r[0]} + {1'b0, pp_idx_r[1]}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r  <= 1'b0;
      mcnt_r   <= '0;
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= mbusy_r;
      if (cmd.mul_start) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= '0;
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r + 1'b1;
        if (mcnt_r == 3'd7) mbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod_a_r <= '0;
      prod_b_r <= '0;
    end
    pp_r     <= mx * my;
    pp_idx_r <= mcnt_r[1:0];
    pp_sec_r <= mcnt_r[2];
    if (pp_vld_r) begin
      if (pp_sec_r) prod_b_r <= prod_b_r + pp_sh;
      else prod_a_r <= prod_a_r + pp_sh;
    end
  end
  assign sts.mul_done = pp_vld_r && !mbusy_r;

  // Variance numerator, shifted left by twice the fraction bits, clamped at zero.
  logic [2*AccBits-1:0] diff;
  logic [2*AccBits-1:0] rad;
  assign diff = (prod_a_r < prod_b_r) ? '0 : prod_a_r - prod_b_r;
  assign rad  = diff << (2 * FracBits);

  // Restoring integer square root, one result bit per cycle.
  logic [2*AccBits-1:0] rem_r;
  logic [RootBits-1:0]  root_r;
  logic [2*AccBits-1:0] rad_r;
  logic [RootCntBits-1:0] rcnt_r;
  logic                 rbusy_r;
  logic [2*AccBits+1:0] rtrial;
  logic [2*AccBits+1:0] rcur;

  assign rcur   = {rem_r, rad_r[2*AccBits-1 -: 2]};
  assign rtrial = rcur - {{(AccBits){1'b0}}, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbusy_r <= 1'b0;
    end else if (cmd.root_start) begin
      rbusy_r <= 1'b1;
    end else if (rbusy_r && rcnt_r == RootCntBits'(RootBits - 1)) begin
      rbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rem_r  <= '0;
      root_r <= '0;
      rad_r  <= rad;
      rcnt_r <= '0;
    end else if (rbusy_r) begin
      rad_r  <= rad_r << 2;
      rcnt_r <= rcnt_r + 1'b1;
      if (!rtrial[2*AccBits+1]) begin
        rem_r  <= rtrial[2*AccBits-1:0];
        root_r <= {root_r[RootBits-2:0], 1'b1};
      end else begin
        rem_r  <= rcur[2*AccBits-1:0];
        root_r <= {root_r[RootBits-2:0], 1'b0};
      end
    end
  end
  assign sts.root_done = !rbusy_r;

  // Shared restoring divider, one quotient bit per cycle.
  logic [DivNumBits-1:0] dnum;
  logic [DivDenBits-1:0] dden;
  logic [DivNumBits-1:0] quo_r;
  logic [DivDenBits:0]   drem_r;
  logic [DivDenBits-1:0] den_r;
  logic [DivCntBits-1:0] dcnt_r;
  logic                  dbusy_r;
  logic [DivDenBits+1:0] dtrial;
  logic [DivDenBits:0]   dshift;
  logic [CountBits+ScaleBits-1:0] cs_prod;
  logic [DivDenBits-1:0] cnt_scale;

  // Count times scale is a 32x16 product.
  assign cs_prod   = count_r * scale_r;
  assign cnt_scale = {{(DivDenBits-CountBits-ScaleBits){1'b0}}, cs_prod};

  always_comb begin
    dden = cnt_scale;
    dnum = '0;
    case (cmd.div_sel)
      SEL_MIN: begin
        dnum = {{(DivNumBits-SampleBits){1'b0}}, min_r} << FracBits;
        dden = {{(DivDenBits-ScaleBits){1'b0}}, scale_r};
      end
      SEL_MAX: begin
        dnum = {{(DivNumBits-SampleBits){1'b0}}, max_r} << FracBits;
        dden = {{(DivDenBits-ScaleBits){1'b0}}, scale_r};
      end
      SEL_MEAN: dnum = {{(DivNumBits-AccBits){1'b0}}, sum_r} << FracBits;
      default:  dnum = {{(DivNumBits-RootBits){1'b0}}, root_r};
    endcase
  end

  assign dshift = {drem_r[DivDenBits-1:0], quo_r[DivNumBits-1]};
  assign dtrial = {1'b0, dshift} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && dcnt_r == DivCntBits'(DivNumBits - 1)) begin
      dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r  <= dnum;
      drem_r <= '0;
      den_r  <= dden;
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (!dtrial[DivDenBits+1]) begin
        drem_r <= dtrial[DivDenBits:0];
        quo_r  <= {quo_r[DivNumBits-2:0], 1'b1};
      end else begin
        drem_r <= dshift;
        quo_r  <= {quo_r[DivNumBits-2:0], 1'b0};
      end
    end
  end
  assign sts.div_done = !dbusy_r;

  // Saturated quotient captured into the matching result field.
  logic [OutBits-1:0] qsat;
  logic [OutBits-1:0] min_q_r;
  logic [OutBits-1:0] max_q_r;
  logic [OutBits-1:0] mean_q_r;
  logic [OutBits-1:0] dev_q_r;
  logic               capture_r;
  rss_sel_t           cap_sel_r;
  assign qsat = (quo_r[DivNumBits-1:OutBits] != '0) ? OutMax : quo_r[OutBits-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_r <= 1'b0;
    end else begin
      capture_r <= dbusy_r && dcnt_r == DivCntBits'(DivNumBits - 1);
    end
    if (cmd.div_start) cap_sel_r <= cmd.div_sel;
    if (capture_r) begin
      case (cap_sel_r)
        SEL_MIN:  min_q_r  <= qsat;
        SEL_MAX:  max_q_r  <= qsat;
        SEL_MEAN: mean_q_r <= (count_r == '0) ? '0 : qsat;
        default:  dev_q_r  <= (count_r == '0) ? '0 : qsat;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_count     <= count_r;
      minimum_scaled   <= min_q_r;
      maximum_scaled   <= max_q_r;
      mean_scaled      <= mean_q_r;
      deviation_scaled <= dev_q_r;
      overflow         <= wrap_r;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rss_ctrl.sv =====
`default_nettype none
module rss_ctrl
  import rss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output rss_cmd_t      cmd,
  input  wire rss_sts_t sts
);
  rss_state_t state_r;
  rss_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       wait_r;

  // A divide or root that was just started still reports done until its busy register is set; wait_r masks that.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wait_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wait_r      <= (state_nxt != state_r);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_ACCUM;
      ST_ACCUM: state_nxt = ST_MUL;
      ST_MUL:   if (!wait_r && sts.mul_done) state_nxt = ST_MIN;
      ST_MIN:   if (!wait_r && sts.div_done) state_nxt = ST_MAX;
      ST_MAX:   if (!wait_r && sts.div_done) state_nxt = ST_MEAN;
      ST_MEAN:  if (!wait_r && sts.div_done) state_nxt = ST_ROOT;
      ST_ROOT:  if (!wait_r && sts.root_done) state_nxt = ST_DEV;
      ST_DEV:   if (!wait_r && sts.div_done) state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd           = '0;
    cmd.div_sel   = SEL_MIN;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_ACCUM: cmd.accum = 1'b1;
      ST_MUL:   cmd.mul_start = wait_r;
      ST_MIN: begin
        cmd.div_sel   = SEL_MIN;
        cmd.div_start = wait_r;
      end
      ST_MAX: begin
        cmd.div_sel   = SEL_MAX;
        cmd.div_start = wait_r;
      end
      ST_MEAN: begin
        cmd.div_sel   = SEL_MEAN;
        cmd.div_start = wait_r;
      end
      ST_ROOT: cmd.root_start = wait_r;
      ST_DEV: begin
        cmd.div_sel   = SEL_DEV;
        cmd.div_start = wait_r;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end
  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// ===== rtl/running_sample_statistics.sv =====
// Each accepted beat runs an 8-step multiply, four 128-step divisions and a
// 64-step square root one after the other on shared units, and the input stalls
// until they finish and the result is loaded.
// A finished result waits in the output register while the next beat is taken;
// a new result waits only while the receiver still stalls the previous one.
// Reset (rst_n low, synchronous) clears the accumulators and sets scale to 1.
`default_nettype none
module running_sample_statistics
  import rss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [ScaleBits-1:0]  cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SampleBits-1:0] in_sample,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CountBits-1:0]       out_sample_count,
  output logic [OutBits-1:0]         out_minimum_scaled,
  output logic [OutBits-1:0]         out_maximum_scaled,
  output logic [OutBits-1:0]         out_mean_scaled,
  output logic [OutBits-1:0]         out_deviation_scaled,
  output logic                       out_overflow
);
  logic [ScaleBits-1:0] scale_r;
  rss_cmd_t cmd;
  rss_sts_t sts;

  // Scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= {{(ScaleBits-1){1'b0}}, 1'b1};
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  rss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  rss_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .sample_in(in_sample), .scale_in(scale_r),
    .sample_count(out_sample_count), .minimum_scaled(out_minimum_scaled),
    .maximum_scaled(out_maximum_scaled), .mean_scaled(out_mean_scaled),
    .deviation_scaled(out_deviation_scaled), .overflow(out_overflow)
  );
endmodule
`default_nettype wire

// ===== rtl/rss_checker.sv =====
`default_nettype none
module rss_checker
  import rss_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [CountBits-1:0] out_sample_count,
  input wire logic                 out_overflow
);
  // A result stalled by the receiver holds its count.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_count))
    else $error("stalled result changed");

  // An overflow beat always reports an emptied count.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_sample_count == '0)
    else $error("overflow with nonzero count");

  // An accepted beat is followed by a stalled input.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accept");

  // Without overflow, a nonzero count follows every result.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> out_sample_count != '0)
    else $error("zero count without overflow");
endmodule

bind running_sample_statistics rss_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_sample_count(out_sample_count), .out_overflow(out_overflow)
);
`default_nettype wire

// ===== tb/sv/running_sample_statistics_test.sv =====
`default_nettype none
module running_sample_statistics_test;
  import rss_pkg::*;

  localparam logic [OutBits-1:0] OutMax = {OutBits{1'b1}};
  localparam int StallLimit = 20000;
  localparam int SettleCycles = 800;
  localparam int PhaseItems = 100;

  typedef struct packed {
    logic [CountBits-1:0] sample_count;
    logic [OutBits-1:0]   minimum_scaled;
    logic [OutBits-1:0]   maximum_scaled;
    logic [OutBits-1:0]   mean_scaled;
    logic [OutBits-1:0]   deviation_scaled;
    logic                 overflow;
  } stats_beat_t;

  // One directed row: the sample, and where it is obvious, the count and flag.
  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  typed;
    logic [CountBits-1:0]  sample_count;
    logic                  overflow;
  } sample_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [ScaleBits-1:0]  cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [SampleBits-1:0] in_sample;
  logic                  out_valid;
  logic                  out_stall;
  logic [CountBits-1:0]  out_sample_count;
  logic [OutBits-1:0]    out_minimum_scaled;
  logic [OutBits-1:0]    out_maximum_scaled;
  logic [OutBits-1:0]    out_mean_scaled;
  logic [OutBits-1:0]    out_deviation_scaled;
  logic                  out_overflow;

  running_sample_statistics u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sample_count     (out_sample_count),
    .out_minimum_scaled   (out_minimum_scaled),
    .out_maximum_scaled   (out_maximum_scaled),
    .out_mean_scaled      (out_mean_scaled),
    .out_deviation_scaled (out_deviation_scaled),
    .out_overflow         (out_overflow)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Shadow copy of the accumulators and the scale register.
  logic [63:0]          shadow_count;
  logic [AccBits-1:0]   shadow_sum;
  logic [AccBits-1:0]   shadow_square_sum;
  logic [SampleBits-1:0] shadow_min;
  logic [SampleBits-1:0] shadow_max;
  logic [ScaleBits-1:0] shadow_scale;

  stats_beat_t pending_stats[$];
  int  error_count;
  int  idle_cycles;
  bit  hold_request;

  function automatic logic [OutBits-1:0] clip_out(input logic [127:0] v);
    clip_out = (v > {88'd0, OutMax}) ? OutMax : v[OutBits-1:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] x);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= x) root = cand;
    end
    floor_root = root;
  endfunction

  // Fold one sample into the shadow state and work out the result beat.
  function automatic stats_beat_t fold_sample(input logic [SampleBits-1:0] sample);
    stats_beat_t r;
    logic [127:0] square;
    logic [127:0] divisor;
    logic [127:0] spread;
    logic [127:0] scale;
    logic         wrap;
    square = {96'd0, sample} * {96'd0, sample};
    scale = (shadow_scale == 0) ? 128'd1 : {112'd0, shadow_scale};
    wrap = (shadow_count >= 64'hFFFF_FFFF)
        || ({64'd0, shadow_sum} + sample > 128'hFFFF_FFFF_FFFF_FFFF)
        || ({64'd0, shadow_square_sum} + square > 128'hFFFF_FFFF_FFFF_FFFF);
    if (wrap) begin
      shadow_count = '0;
      shadow_sum = '0;
      shadow_square_sum = '0;
    end else begin
      shadow_count = shadow_count + 1;
      shadow_sum = shadow_sum + sample;
      shadow_square_sum = shadow_square_sum + square[63:0];
      if (sample > shadow_max) shadow_max = sample;
      if (shadow_min == 0 || sample < shadow_min) shadow_min = sample;
    end
    r.sample_count = shadow_count[CountBits-1:0];
    r.minimum_scaled = clip_out(({96'd0, shadow_min} << FracBits) / scale);
    r.maximum_scaled = clip_out(({96'd0, shadow_max} << FracBits) / scale);
    r.overflow = wrap;
    if (shadow_count == 0) begin
      r.mean_scaled = '0;
      r.deviation_scaled = '0;
    end else begin
      divisor = {64'd0, shadow_count} * scale;
      r.mean_scaled = clip_out(({64'd0, shadow_sum} << FracBits) / divisor);
      // A negative spread cannot come from real samples; it would count as zero.
      if ({64'd0, shadow_count} * {64'd0, shadow_square_sum} <
          {64'd0, shadow_sum} * {64'd0, shadow_sum})
        spread = '0;
      else
        spread = {64'd0, shadow_count} * {64'd0, shadow_square_sum}
               - {64'd0, shadow_sum} * {64'd0, shadow_sum};
      spread = spread << (2 * FracBits);
      r.deviation_scaled = clip_out({64'd0, floor_root(spread)} / divisor);
    end
    fold_sample = r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Compare each result beat with the oldest pending expectation.
  always @(posedge clk) begin
    stats_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("unexpected beat", out_sample_count, 0);
      end else begin
        want = pending_stats.pop_front();
        if (out_sample_count !== want.sample_count)
          report_mismatch("sample_count", out_sample_count, want.sample_count);
        if (out_minimum_scaled !== want.minimum_scaled)
          report_mismatch("minimum_scaled", out_minimum_scaled, want.minimum_scaled);
        if (out_maximum_scaled !== want.maximum_scaled)
          report_mismatch("maximum_scaled", out_maximum_scaled, want.maximum_scaled);
        if (out_mean_scaled !== want.mean_scaled)
          report_mismatch("mean_scaled", out_mean_scaled, want.mean_scaled);
        if (out_deviation_scaled !== want.deviation_scaled)
          report_mismatch("deviation_scaled", out_deviation_scaled,
                          want.deviation_scaled);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
      end
    end
  end

  // Watchdog: cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall patterns that change every so often, plus one long hold-off.
  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(50, 400)) begin
        @(posedge clk);
        if (hold_request) begin
          out_stall <= 1'b1;
          repeat (3000) @(posedge clk);
          hold_request = 1'b0;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          2: out_stall <= ($urandom_range(0, 9) < 8);
          default: out_stall <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  int burst_left;

  // Offer one beat; the payload holds until it is accepted.
  task automatic send_sample(input logic [SampleBits-1:0] sample, input bit typed,
                             input logic [CountBits-1:0] count,
                             input logic ovf);
    stats_beat_t want;
    if (burst_left == 0) begin
      // A gap, taken at random, drops valid before the next burst.
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    want = fold_sample(sample);
    if (typed) begin
      want.sample_count = count;
      want.overflow = ovf;
    end
    pending_stats.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(input logic [ScaleBits-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_scale = value;
  endtask

  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: pick_sample = '0;
      1: pick_sample = '1;
      2, 3: pick_sample = $urandom_range(0, 255);
      4: pick_sample = $urandom_range(0, 65535);
      default: pick_sample = $urandom;
    endcase
  endfunction

  sample_row_t directed_rows[] = '{
    '{32'h0000_0000, 1'b1, 32'd1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 32'd2, 1'b0},
    // Two full-scale squares wrap the square sum.
    '{32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1},
    '{32'h0000_0001, 1'b1, 32'd1, 1'b0},
    '{32'h8000_0000, 1'b1, 32'd2, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 32'd3, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 32'd4, 1'b0},
    '{32'h5555_5555, 1'b1, 32'd0, 1'b1},
    '{32'h0000_0000, 1'b1, 32'd1, 1'b0},
    '{32'h0000_0002, 1'b1, 32'd2, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 32'd3, 1'b0},
    '{32'h0000_FFFF, 1'b1, 32'd4, 1'b0},
    '{32'h0000_0003, 1'b0, 32'd0, 1'b0},
    '{32'h1234_5678, 1'b0, 32'd0, 1'b0}
  };

  logic [ScaleBits-1:0] phase_scales[] = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0003,
                                           16'h0000, 16'h0000};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_sample = '0;
    error_count = 0;
    idle_cycles = 0;
    hold_request = 1'b0;
    burst_left = 0;
    shadow_count = '0;
    shadow_sum = '0;
    shadow_square_sum = '0;
    shadow_min = '0;
    shadow_max = '0;
    shadow_scale = 16'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset scale.
    foreach (directed_rows[i])
      send_sample(directed_rows[i].sample, directed_rows[i].typed,
                  directed_rows[i].sample_count, directed_rows[i].overflow);
    drain_results();

    // Random phases, each under its own scale.
    phase_scales[4] = $urandom_range(1, 65535);
    phase_scales[5] = $urandom_range(2, 300);
    foreach (phase_scales[p]) begin
      write_scale(phase_scales[p]);
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 2 && k == 10) hold_request = 1'b1;
        send_sample(pick_sample(), 1'b0, '0, 1'b0);
      end
      drain_results();
    end

    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0 && pending_stats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rss_pkg.sv
rtl/rss_datapath.sv
rtl/rss_ctrl.sv
rtl/running_sample_statistics.sv
rtl/rss_checker.sv
tb/sv/running_sample_statistics_test.sv
